/* rtl/rmt_pkg.sv */
// ----------------------------------------------------------------------------
// rmt_pkg: shared types and codes of the recursive mutex table
// Operation codes, status codes and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package rmt_pkg;

    // Field widths of the request and result channels
    localparam int FUNC_W   = 3;
    localparam int SLOT_W   = 6;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 3;
    localparam int SLOUT_W  = 5;
    localparam int DEPTH_W  = 8;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_INIT    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_DESTROY = 3'd1;
    localparam logic [FUNC_W-1:0] FN_LOCK    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_TRYLOCK = 3'd3;
    localparam logic [FUNC_W-1:0] FN_UNLOCK  = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY        = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_OWNER   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_FREE     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_WOULD_BLOCK = 3'd5;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 3'd6;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture request, read table entry
        logic commit;   // decide, write back, load result register
    } t_rmt_cmd;

endpackage

/* rtl/rmt_intf.sv */
// ----------------------------------------------------------------------------
// rmt_intf: request and response channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface rmt_req_if import rmt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [SLOT_W-1:0] slot_sel;
    logic [ID_W-1:0]   requester_id;

    modport source (output valid, func, slot_sel, requester_id, input ready);
    modport sink   (input valid, func, slot_sel, requester_id, output ready);
endinterface

interface rmt_rsp_if import rmt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOUT_W-1:0]  slot_out;
    logic                wake_waiter;
    logic [DEPTH_W-1:0]  hold_depth;

    modport source (output valid, status, slot_out, wake_waiter, hold_depth,
                    input ready);
    modport sink   (input valid, status, slot_out, wake_waiter, hold_depth,
                    output ready);
endinterface

/* rtl/recursive_mutex_table.sv */
// ----------------------------------------------------------------------------
// recursive_mutex_table: table of recursive mutexes
// Serves init, destroy, lock, trylock and unlock requests, one result each.
// ----------------------------------------------------------------------------
// The transfer cycle captures the request and reads the slot's owner and hold
// count from the table memory, and the decision state then decides the
// operation (including the lowest-free-slot search for init), writes the
// entry back and loads the result register. A new request is taken in the
// cycle after that, while the previous result may still wait in the result
// register; the decision cycle waits only if that register is still full and
// not being taken. Lock flags and waiter flags clear at reset, so the block is
// usable immediately after reset.
module recursive_mutex_table import rmt_pkg::*; #(
    parameter int SLOTS      = 32,
    parameter int OWNER_BITS = 16,
    parameter int DEPTH_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rmt_req_if.sink   i_req,
    rmt_rsp_if.source o_rsp
);

    t_rmt_cmd cmd;

    rmt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    rmt_dpath #(
        .SLOTS      (SLOTS),
        .OWNER_BITS (OWNER_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_func         (i_req.func),
        .i_slot_sel     (i_req.slot_sel),
        .i_requester_id (i_req.requester_id),
        .o_status       (o_rsp.status),
        .o_slot_out     (o_rsp.slot_out),
        .o_wake_waiter  (o_rsp.wake_waiter),
        .o_hold_depth   (o_rsp.hold_depth)
    );

endmodule

/* rtl/rmt_ctrl.sv */
// ----------------------------------------------------------------------------
// rmt_ctrl: request sequencer
// Two-state controller: take a request, then commit it once the result
// register is free. Owns the handshake on both channels.
// ----------------------------------------------------------------------------
module rmt_ctrl import rmt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_rmt_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   commit;

    // Commit only when the result register is empty or being drained
    assign commit     = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.commit = commit;
    assign o_out_valid  = r_out_valid;

    // Advance state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold result valid until transfer, reload on commit
    always_comb begin
        n_out_valid = r_out_valid;
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/rmt_dpath.sv */
// ----------------------------------------------------------------------------
// rmt_dpath: mutex table datapath
// Lock and waiter flags in flops, owner and hold count in a memory read
// at request capture. Decides the operation and writes back on commit.
// ----------------------------------------------------------------------------
module rmt_dpath import rmt_pkg::*; #(
    parameter int SLOTS      = 32,
    parameter int OWNER_BITS = 16,
    parameter int DEPTH_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_rmt_cmd            i_cmd,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [SLOT_W-1:0]   i_slot_sel,
    input  logic [ID_W-1:0]     i_requester_id,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOUT_W-1:0]  o_slot_out,
    output logic                o_wake_waiter,
    output logic [DEPTH_W-1:0]  o_hold_depth
);

    localparam int SIDX = $clog2(SLOTS);

    // Request register
    logic [FUNC_W-1:0]     r_func;
    logic [SLOT_W-1:0]     r_slot;
    logic [OWNER_BITS-1:0] r_me;

    // Table: flags in flops, owner and count in memory
    logic [SLOTS-1:0]      r_locked;
    logic [SLOTS-1:0]      r_waiter;
    logic [OWNER_BITS-1:0] mem_own [SLOTS];
    logic [DEPTH_BITS-1:0] mem_cnt [SLOTS];
    logic [OWNER_BITS-1:0] r_rd_own;
    logic [DEPTH_BITS-1:0] r_rd_cnt;

    // Result register
    logic [STATUS_W-1:0] r_status;
    logic [SLOUT_W-1:0]  r_slot_out;
    logic                r_wake;
    logic [DEPTH_W-1:0]  r_depth;

    // Decision signals
    logic [SIDX-1:0]       idx;
    logic [SIDX-1:0]       rd_addr;
    logic                  in_range;
    logic                  cur_lk;
    logic                  own_me;
    logic [DEPTH_BITS-1:0] cur_cnt;
    logic                  found;
    logic [SIDX-1:0]       free_idx;
    logic [STATUS_W-1:0]   n_status;
    logic [SLOUT_W-1:0]    n_slot_out;
    logic                  n_wake;
    logic [DEPTH_BITS-1:0] n_depth;
    logic                  wr_en;
    logic [OWNER_BITS-1:0] wr_own;
    logic [DEPTH_BITS-1:0] wr_cnt;
    logic                  set_lk;
    logic                  clr_lk;
    logic                  set_wt;
    logic                  clr_wt;
    logic [SIDX-1:0]       flag_idx;

    assign rd_addr  = i_slot_sel[SIDX-1:0];
    assign idx      = r_slot[SIDX-1:0];
    assign in_range = {1'b0, r_slot} < (SLOT_W+1)'(SLOTS);

    // Capture request and read the addressed entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= i_func;
            r_slot   <= i_slot_sel;
            r_me     <= OWNER_BITS'(i_requester_id);
            r_rd_own <= mem_own[rd_addr];
            r_rd_cnt <= mem_cnt[rd_addr];
        end
    end

    // An unlocked slot always reads as count zero and is owned by no requester
    assign cur_lk  = r_locked[idx];
    assign cur_cnt = cur_lk ? r_rd_cnt : '0;
    assign own_me  = cur_lk && (r_rd_own == r_me);

    // Find the lowest unlocked slot for init
    always_comb begin
        found    = 1'b0;
        free_idx = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (!r_locked[k]) begin
                found    = 1'b1;
                free_idx = SIDX'(k);
            end
        end
    end

    // Decide the operation
    always_comb begin
        n_status   = ST_INVALID;
        n_slot_out = SLOUT_W'(r_slot);
        n_wake     = 1'b0;
        n_depth    = '0;
        wr_en      = 1'b0;
        wr_own     = r_me;
        wr_cnt     = '0;
        set_lk     = 1'b0;
        clr_lk     = 1'b0;
        set_wt     = 1'b0;
        clr_wt     = 1'b0;
        flag_idx   = idx;
        if (r_func == FN_INIT) begin
            if (found) begin
                n_status   = ST_OK;
                n_slot_out = SLOUT_W'(free_idx);
                clr_wt     = 1'b1;
                flag_idx   = free_idx;
            end else begin
                n_status   = ST_NO_FREE;
                n_slot_out = '0;
            end
        end else if (in_range) begin
            case (r_func) inside
                FN_DESTROY: begin
                    n_status = cur_lk ? ST_BUSY : ST_OK;
                    n_depth  = cur_cnt;
                end
                FN_LOCK, FN_TRYLOCK: begin
                    n_depth = cur_cnt;
                    if (cur_lk && !own_me) begin
                        // Foreign hold: lock marks a waiter
                        n_status = (r_func == FN_LOCK) ? ST_WOULD_BLOCK : ST_BUSY;
                        set_wt   = (r_func == FN_LOCK);
                    end else if (cur_lk) begin
                        if (&cur_cnt) begin
                            n_status = ST_OVERFLOW;
                        end else begin
                            n_status = ST_OK;
                            wr_en    = 1'b1;
                            wr_own   = r_rd_own;
                            wr_cnt   = cur_cnt + 1'b1;
                            n_depth  = cur_cnt + 1'b1;
                        end
                    end else begin
                        n_status = ST_OK;
                        set_lk   = 1'b1;
                        wr_en    = 1'b1;
                        wr_cnt   = DEPTH_BITS'(1);
                        n_depth  = DEPTH_BITS'(1);
                    end
                end
                FN_UNLOCK: begin
                    n_depth = cur_cnt;
                    if (!own_me) begin
                        n_status = ST_NOT_OWNER;
                    end else if (cur_cnt <= DEPTH_BITS'(1)) begin
                        // Final release: free the slot, wake any marked waiter
                        n_status = ST_OK;
                        n_wake   = r_waiter[idx];
                        n_depth  = '0;
                        clr_lk   = 1'b1;
                        clr_wt   = 1'b1;
                    end else begin
                        n_status = ST_OK;
                        wr_en    = 1'b1;
                        wr_own   = r_rd_own;
                        wr_cnt   = cur_cnt - 1'b1;
                        n_depth  = cur_cnt - 1'b1;
                    end
                end
                default: begin
                    n_status = ST_INVALID;
                end
            endcase
        end
    end

    // Write back owner and count
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wr_en) begin
            mem_own[idx] <= wr_own;
            mem_cnt[idx] <= wr_cnt;
        end
    end

    // Update lock and waiter flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locked <= '0;
            r_waiter <= '0;
        end else if (i_cmd.commit) begin
            if (set_lk) begin
                r_locked[flag_idx] <= 1'b1;
            end else if (clr_lk) begin
                r_locked[flag_idx] <= 1'b0;
            end
            if (set_wt) begin
                r_waiter[flag_idx] <= 1'b1;
            end else if (clr_wt) begin
                r_waiter[flag_idx] <= 1'b0;
            end
        end
    end

    // Load result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status   <= n_status;
            r_slot_out <= n_slot_out;
            r_wake     <= n_wake;
            r_depth    <= DEPTH_W'(n_depth);
        end
    end

    assign o_status      = r_status;
    assign o_slot_out    = r_slot_out;
    assign o_wake_waiter = r_wake;
    assign o_hold_depth  = r_depth;

endmodule

/* rtl/rmt_checker.sv */
// ----------------------------------------------------------------------------
// rmt_checker: port-level checks of the mutex table
// Watches both channels and checks sequencing and result sanity.
// ----------------------------------------------------------------------------
module rmt_checker import rmt_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [STATUS_W-1:0] i_status,
    input logic [SLOUT_W-1:0]  i_slot_out,
    input logic                i_wake_waiter,
    input logic [DEPTH_W-1:0]  i_hold_depth
);

    logic in_xfer;

    assign in_xfer = i_in_valid && i_in_ready;

    // Stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_slot_out) && $stable(i_wake_waiter) && $stable(i_hold_depth))
        else $error("result changed while stalled");

    // One request at a time: no transfer right after a transfer
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !in_xfer)
        else $error("back-to-back request transfer");

    // A result is offered after a request transfer: the new one or a stalled earlier one
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> ##1 i_out_valid)
        else $error("no result after request");

    // A wake only comes from a successful final release
    a_wake_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_wake_waiter |-> i_status == ST_OK && i_hold_depth == '0)
        else $error("wake on a result that is not a final release");

endmodule

bind recursive_mutex_table rmt_checker u_rmt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_status      (o_rsp.status),
    .i_slot_out    (o_rsp.slot_out),
    .i_wake_waiter (o_rsp.wake_waiter),
    .i_hold_depth  (o_rsp.hold_depth)
);

/* verif/recursive_mutex_table_test.sv */
// ----------------------------------------------------------------------------
// recursive_mutex_table_test: self-checking bench of the recursive mutex table
// Drives init, destroy, lock, trylock and unlock requests with random gaps and
// response stalls, keeps its own copy of the table to work out each result,
// and compares every response transfer field by field with the oldest one.
// ----------------------------------------------------------------------------
module recursive_mutex_table_test import rmt_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SLOTS   = 32;
    localparam int MAX_LEVEL     = 255;
    localparam int RANDOM_ITEMS  = 250;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOUT_W-1:0]  slot_out;
        logic                wake_waiter;
        logic [DEPTH_W-1:0]  hold_depth;
    } lock_result_t;

    logic i_clk;
    logic i_rst_n;

    rmt_req_if req_if ();
    rmt_rsp_if rsp_if ();

    recursive_mutex_table #(
        .SLOTS      (TABLE_SLOTS),
        .OWNER_BITS (ID_W),
        .DEPTH_BITS (DEPTH_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow copy of the mutex table
    bit                 held       [TABLE_SLOTS];
    logic [ID_W-1:0]    holder     [TABLE_SLOTS];
    logic [DEPTH_W-1:0] hold_level [TABLE_SLOTS];
    bit                 waiting    [TABLE_SLOTS];

    lock_result_t    pending_results [$];
    logic [ID_W-1:0] id_pool [4];
    int              requests_sent;
    int              error_count;
    int              quiet_cycles;
    bit              no_idle;

    // Clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Apply one request to the shadow table and return the expected response
    function automatic lock_result_t apply_request(input logic [FUNC_W-1:0] fn,
                                                   input logic [SLOT_W-1:0] slot,
                                                   input logic [ID_W-1:0]   id);
        lock_result_t r;
        int           s;
        bit           found;
        r     = '0;
        s     = int'(slot);
        found = 1'b0;
        if (fn == FN_INIT) begin
            r.status = ST_NO_FREE;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (!found && !held[i] && holder[i] == '0) begin
                    found         = 1'b1;
                    hold_level[i] = '0;
                    waiting[i]    = 1'b0;
                    r.status      = ST_OK;
                    r.slot_out    = i[SLOUT_W-1:0];
                end
            end
            return r;
        end
        r.slot_out = slot[SLOUT_W-1:0];
        if (fn > FN_UNLOCK || s >= TABLE_SLOTS) begin
            r.status = ST_INVALID;
            return r;
        end
        case (fn) inside
            FN_DESTROY: begin
                r.hold_depth = hold_level[s];
                if (held[s]) begin
                    r.status = ST_BUSY;
                end else begin
                    holder[s] = '0;
                    r.status  = ST_OK;
                end
            end
            FN_LOCK, FN_TRYLOCK: begin
                if (held[s] && holder[s] != id) begin
                    if (fn == FN_LOCK) begin
                        waiting[s] = 1'b1;
                        r.status   = ST_WOULD_BLOCK;
                    end else begin
                        r.status = ST_BUSY;
                    end
                end else if (held[s]) begin
                    if (hold_level[s] == MAX_LEVEL) begin
                        r.status = ST_OVERFLOW;
                    end else begin
                        hold_level[s] = hold_level[s] + 1'b1;
                        r.status      = ST_OK;
                    end
                end else begin
                    held[s]       = 1'b1;
                    holder[s]     = id;
                    hold_level[s] = DEPTH_W'(1);
                    r.status      = ST_OK;
                end
                r.hold_depth = hold_level[s];
            end
            default: begin
                if (!held[s] || holder[s] != id) begin
                    r.status     = ST_NOT_OWNER;
                    r.hold_depth = hold_level[s];
                end else if (hold_level[s] <= 1) begin
                    r.wake_waiter = waiting[s];
                    held[s]       = 1'b0;
                    holder[s]     = '0;
                    hold_level[s] = '0;
                    waiting[s]    = 1'b0;
                    r.status      = ST_OK;
                end else begin
                    hold_level[s] = hold_level[s] - 1'b1;
                    r.status      = ST_OK;
                    r.hold_depth  = hold_level[s];
                end
            end
        endcase
        return r;
    endfunction

    // Send one request; record its expected response at the transfer
    task automatic send_request(input logic [FUNC_W-1:0] fn,
                                input logic [SLOT_W-1:0] slot,
                                input logic [ID_W-1:0]   id);
        @(negedge i_clk);
        if (!no_idle) begin
            while ($urandom_range(99) < 24) begin
                req_if.valid = 1'b0;
                @(negedge i_clk);
            end
        end
        req_if.valid        = 1'b1;
        req_if.func         = fn;
        req_if.slot_sel     = slot;
        req_if.requester_id = id;
        do @(posedge i_clk); while (!req_if.ready);
        pending_results.push_back(apply_request(fn, slot, id));
        requests_sent++;
    endtask

    // Pick a caller id: mostly from a small pool so that holds collide
    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(9)) inside
            0:       return '0;
            1:       return '1;
            [2:7]:   return id_pool[$urandom_range(3)];
            default: return ID_W'($urandom);
        endcase
    endfunction

    // Response stalls
    always @(negedge i_clk) begin
        rsp_if.ready = no_idle ? 1'b1 : ($urandom_range(99) >= 24);
    end

    // Compare each response transfer with the oldest expected one
    always @(posedge i_clk) begin
        lock_result_t want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("response with none expected: status %0d slot %0d",
                       rsp_if.status, rsp_if.slot_out);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (rsp_if.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                    error_count++;
                end
                if (rsp_if.slot_out !== want.slot_out) begin
                    $error("slot_out: expected %0d, got %0d", want.slot_out,
                           rsp_if.slot_out);
                    error_count++;
                end
                if (rsp_if.wake_waiter !== want.wake_waiter) begin
                    $error("wake_waiter: expected %0d, got %0d", want.wake_waiter,
                           rsp_if.wake_waiter);
                    error_count++;
                end
                if (rsp_if.hold_depth !== want.hold_depth) begin
                    $error("hold_depth: expected %0d, got %0d", want.hold_depth,
                           rsp_if.hold_depth);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready)
                || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("recursive_mutex_table test failed");
                $finish;
            end
        end
    end

    // Lock ownership, recursion, foreign holds, wakeup and invalid requests
    task automatic check_basic_operations();
        send_request(FN_INIT, 6'd0, 16'h0000);          // empty table: slot 0
        send_request(FN_LOCK, 6'd0, 16'h0000);          // id zero owns slot 0
        send_request(FN_LOCK, 6'd0, 16'h0000);          // recursion
        send_request(FN_TRYLOCK, 6'd0, 16'hFFFF);       // foreign: busy
        send_request(FN_LOCK, 6'd0, 16'hFFFF);          // foreign: mark waiter
        send_request(FN_DESTROY, 6'd0, 16'h0000);       // locked: busy
        send_request(FN_UNLOCK, 6'd0, 16'hFFFF);        // not owner
        send_request(FN_INIT, 6'd63, 16'hFFFF);         // skip locked slot 0
        send_request(FN_UNLOCK, 6'd0, 16'h0000);
        send_request(FN_UNLOCK, 6'd0, 16'h0000);        // final, wakes waiter
        send_request(FN_UNLOCK, 6'd0, 16'h0000);        // already free
        send_request(FN_DESTROY, 6'd0, 16'h0000);       // unlocked: ok
        send_request(FN_TRYLOCK, 6'd31, 16'hFFFF);
        send_request(FN_TRYLOCK, 6'd31, 16'hFFFF);
        send_request(FN_UNLOCK, 6'd31, 16'hFFFF);
        send_request(FN_UNLOCK, 6'd31, 16'hFFFF);       // final, no waiter
        send_request(FN_LOCK, 6'd32, 16'h1234);         // out of range
        send_request(FN_UNLOCK, 6'd63, 16'h1234);
        send_request(FN_DESTROY, 6'd40, 16'h0000);
        send_request(3'd5, 6'd3, 16'h0001);             // unknown operations
        send_request(3'd6, 6'd63, 16'hFFFF);
        send_request(3'd7, 6'd0, 16'h0000);
    endtask

    // Fill every slot, see init report no free slot, then free them again
    task automatic check_full_table();
        logic [ID_W-1:0] id;
        id = ID_W'($urandom);
        for (int s = 0; s < TABLE_SLOTS; s++)
            send_request(($urandom_range(1) != 0) ? FN_LOCK : FN_TRYLOCK,
                         SLOT_W'(s), id);
        send_request(FN_INIT, 6'd0, id);
        send_request(FN_UNLOCK, 6'd17, id);
        send_request(FN_INIT, 6'd0, id);                // hands out slot 17
        send_request(FN_INIT, 6'd0, id);                // 17 again
        for (int s = 0; s < TABLE_SLOTS; s++)
            send_request(FN_UNLOCK, SLOT_W'(s), id);
    endtask

    // Deepen one hold to the limit, overflow it, then unwind; no idling here
    task automatic check_depth_overflow();
        logic [ID_W-1:0] id;
        id      = 16'hA5C3;
        no_idle = 1'b1;
        for (int k = 0; k < MAX_LEVEL; k++)
            send_request(($urandom_range(1) != 0) ? FN_LOCK : FN_TRYLOCK, 6'd9, id);
        send_request(FN_LOCK, 6'd9, id);
        send_request(FN_TRYLOCK, 6'd9, id);
        send_request(FN_LOCK, 6'd9, 16'h5A3C);          // foreign: mark waiter
        for (int k = 0; k < MAX_LEVEL; k++)
            send_request(FN_UNLOCK, 6'd9, id);
        no_idle = 1'b0;
    endtask

    // Random hold/release sequences mixed with stray requests
    task automatic check_random_traffic();
        int              first;
        int              levels;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0] owner;
        logic [ID_W-1:0] other;
        logic [FUNC_W-1:0] fn;
        first = requests_sent;
        while (requests_sent - first < RANDOM_ITEMS) begin
            if ($urandom_range(99) < 65) begin
                // hold a slot, let a second caller interfere, release it
                slot   = ($urandom_range(3) != 0) ? SLOT_W'($urandom_range(7))
                                                  : SLOT_W'($urandom_range(31));
                owner  = pick_id();
                other  = pick_id();
                levels = $urandom_range(1, 4);
                for (int k = 0; k < levels; k++) begin
                    send_request(($urandom_range(1) != 0) ? FN_LOCK : FN_TRYLOCK,
                                 slot, owner);
                    if ($urandom_range(99) < 30)
                        send_request(FN_FUNC_PICK(), slot, other);
                end
                if ($urandom_range(99) >= 15) begin
                    for (int k = 0; k < levels; k++) begin
                        send_request(FN_UNLOCK, slot, owner);
                        if ($urandom_range(99) < 20)
                            send_request(FN_FUNC_PICK(), slot, other);
                    end
                end
                if ($urandom_range(99) < 30)
                    send_request(FN_DESTROY, slot, owner);
            end else begin
                // stray request, occasionally an unknown operation or bad slot
                fn = ($urandom_range(99) < 88) ? FUNC_W'($urandom_range(4))
                                               : FUNC_W'($urandom_range(5, 7));
                slot = ($urandom_range(99) < 80) ? SLOT_W'($urandom_range(31))
                                                 : SLOT_W'($urandom_range(63));
                send_request(fn, slot, pick_id());
            end
        end
    endtask

    // Operation a competing caller tries on a held slot
    function automatic logic [FUNC_W-1:0] FN_FUNC_PICK();
        case ($urandom_range(3))
            0:       return FN_LOCK;
            1:       return FN_TRYLOCK;
            2:       return FN_UNLOCK;
            default: return FN_DESTROY;
        endcase
    endfunction

    // Reset, run the tests in turn, drain and report
    initial begin
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.func         = FN_INIT;
        req_if.slot_sel     = '0;
        req_if.requester_id = '0;
        rsp_if.ready        = 1'b0;
        no_idle             = 1'b0;
        requests_sent       = 0;
        error_count         = 0;
        quiet_cycles        = 0;
        for (int s = 0; s < TABLE_SLOTS; s++) begin
            held[s]       = 1'b0;
            holder[s]     = '0;
            hold_level[s] = '0;
            waiting[s]    = 1'b0;
        end
        for (int k = 0; k < 4; k++)
            id_pool[k] = ID_W'($urandom);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        check_basic_operations();
        check_full_table();
        check_depth_overflow();
        check_random_traffic();

        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("recursive_mutex_table test passed");
        end else begin
            $display("recursive_mutex_table test failed");
        end
        $finish;
    end

endmodule
